[rtl/ffsa_pkg.sv]
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared constants, codes and beat types of the first-fit slot allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int TAG_BITS  = 16;

    localparam int CNT_BITS  = 9;
    localparam int IDX_BITS  = 8;
    localparam int OWN_BITS  = 16;
    localparam int VAL_BITS  = 16;

    localparam int SLOT_BITS = $clog2(MAX_SLOTS);
    localparam int SRCH_BITS = (SLOT_BITS < 2) ? 2 : SLOT_BITS;
    localparam int HI_BITS   = SRCH_BITS / 2;
    localparam int LO_BITS   = SRCH_BITS - HI_BITS;
    localparam int NUM_GRP   = 2 ** HI_BITS;
    localparam int GRP_SIZE  = 2 ** LO_BITS;
    localparam int VEC_BITS  = NUM_GRP * GRP_SIZE;

    localparam int TAG_KEEP  = (TAG_BITS < OWN_BITS) ? TAG_BITS : OWN_BITS;
    localparam logic [OWN_BITS-1:0] TAG_MASK = OWN_BITS'((64'd1 << TAG_KEEP) - 64'd1);

    localparam int CAP_MAX   = (MAX_SLOTS > (2 ** CNT_BITS) - 1) ? (2 ** CNT_BITS) - 1
                                                                 : MAX_SLOTS;
    localparam logic [CNT_BITS-1:0] CAP_LIMIT = CNT_BITS'(CAP_MAX);

    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef enum logic [1:0] {
        CMD_RESERVE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_QUERY   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROUP,
        S_SLOT,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        t_cmd                command;
        logic [IDX_BITS-1:0] slot_index;
        logic [OWN_BITS-1:0] owner_tag;
    } t_in_beat;

    typedef struct packed {
        logic                status;
        logic [VAL_BITS-1:0] result_value;
        logic [CNT_BITS-1:0] free_slots;
        logic [CNT_BITS-1:0] used_slots;
    } t_out_beat;

    typedef struct packed {
        logic                 clear_all;
        logic [CNT_BITS-1:0]  cap;
        logic                 grp_load;
        logic                 set_en;
        logic                 clr_en;
        logic [SLOT_BITS-1:0] addr;
    } t_srch_ctrl;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
        logic                 occ;
    } t_srch_stat;

endpackage

[rtl/ffsa_tag_ram.sv]
// ----------------------------------------------------------------------------
// ffsa_tag_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffsa_tag_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ffsa_free_search.sv]
// ----------------------------------------------------------------------------
// ffsa_free_search
// Occupancy bits with capacity mask and a two-level registered first-free search.
// ----------------------------------------------------------------------------
module ffsa_free_search (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffsa_pkg::t_srch_ctrl  i_ctrl,
    output ffsa_pkg::t_srch_stat  o_stat
);

    logic [ffsa_pkg::VEC_BITS-1:0] r_occ;
    logic [ffsa_pkg::VEC_BITS-1:0] r_cap_mask;
    logic [ffsa_pkg::HI_BITS-1:0]  r_grp;
    logic                          r_grp_hit;

    logic [ffsa_pkg::VEC_BITS-1:0] avail;
    logic [ffsa_pkg::NUM_GRP-1:0]  grp_any;
    logic [ffsa_pkg::HI_BITS-1:0]  first_grp;
    logic [ffsa_pkg::GRP_SIZE-1:0] grp_bits;
    logic [ffsa_pkg::LO_BITS-1:0]  first_lo;
    logic [ffsa_pkg::SRCH_BITS-1:0] found;
    logic [ffsa_pkg::SRCH_BITS-1:0] addr_ext;

    assign avail    = r_cap_mask & ~r_occ;
    assign addr_ext = ffsa_pkg::SRCH_BITS'(i_ctrl.addr);

    always_comb begin
        grp_any   = '0;
        first_grp = '0;
        for (int g = 0; g < ffsa_pkg::NUM_GRP; g++) begin
            grp_any[g] = |avail[g*ffsa_pkg::GRP_SIZE +: ffsa_pkg::GRP_SIZE];
        end
        for (int g = ffsa_pkg::NUM_GRP - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                first_grp = ffsa_pkg::HI_BITS'(g);
            end
        end
    end

    always_comb begin
        grp_bits = avail[{r_grp, {ffsa_pkg::LO_BITS{1'b0}}} +: ffsa_pkg::GRP_SIZE];
        first_lo = '0;
        for (int b = ffsa_pkg::GRP_SIZE - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                first_lo = ffsa_pkg::LO_BITS'(b);
            end
        end
        found = {r_grp, first_lo};
    end

    assign o_stat.hit  = r_grp_hit && (|grp_bits);
    assign o_stat.slot = ffsa_pkg::SLOT_BITS'(found);
    assign o_stat.occ  = r_occ[addr_ext];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_cap_mask <= '0;
            r_grp_hit  <= 1'b0;
        end else if (i_ctrl.clear_all) begin
            r_occ     <= '0;
            r_grp_hit <= 1'b0;
            for (int i = 0; i < ffsa_pkg::VEC_BITS; i++) begin
                r_cap_mask[i] <= (32'(i) < 32'(i_ctrl.cap));
            end
        end else begin
            if (i_ctrl.grp_load) begin
                r_grp_hit <= |grp_any;
            end
            if (i_ctrl.set_en) begin
                r_occ[addr_ext] <= 1'b1;
            end else if (i_ctrl.clr_en) begin
                r_occ[addr_ext] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.grp_load) begin
            r_grp <= first_grp;
        end
    end

endmodule

[rtl/first_fit_slot_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_core
// Owner-tag slot table with first-fit reserve, release and query commands.
// ----------------------------------------------------------------------------
// One command is in flight at a time. A release or query passes through
// accept, tag RAM read and result beat. A reserve passes through accept,
// then the first-free search as two levels (a registered group pick, then
// the slot within that group, which feeds the tag RAM write), then the
// result beat. A command rejected on its own fields or on a zero capacity
// goes straight to the result beat. The input is not ready while a result
// waits, so the output side's stalls add directly. Owner tags live in a
// RAM; occupancy lives in per-slot flip-flops, so a capacity write clears
// the table with no clearing pass. A capacity above the table size
// saturates.
module first_fit_slot_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffsa_pkg::CNT_BITS-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ffsa_pkg::t_in_beat            i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ffsa_pkg::t_out_beat           o_data
);

    ffsa_pkg::t_state               r_state, n_state;
    ffsa_pkg::t_in_beat             r_in;
    logic [ffsa_pkg::OWN_BITS-1:0]  r_tag;
    logic [ffsa_pkg::CNT_BITS-1:0]  r_cap;
    logic [ffsa_pkg::CNT_BITS-1:0]  r_free, n_free;
    logic                           r_status, n_status;
    logic [ffsa_pkg::VAL_BITS-1:0]  r_value, n_value;

    ffsa_pkg::t_srch_ctrl           srch_ctrl;
    ffsa_pkg::t_srch_stat           srch_stat;

    logic                           in_acc;
    logic                           cfg_acc;
    logic [ffsa_pkg::CNT_BITS-1:0]  cap_sat;
    logic [ffsa_pkg::OWN_BITS-1:0]  tag_m;
    logic                           idx_ok;
    logic                           rej_early;
    logic                           ram_we;
    logic [ffsa_pkg::OWN_BITS-1:0]  ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign cap_sat     = (i_cfg_data > ffsa_pkg::CAP_LIMIT) ? ffsa_pkg::CAP_LIMIT : i_cfg_data;
    assign in_acc      = i_valid && o_ready;

    assign tag_m  = i_data.owner_tag & ffsa_pkg::TAG_MASK;
    assign idx_ok = ({1'b0, i_data.slot_index} < r_cap) &&
                    (32'(i_data.slot_index) < ffsa_pkg::MAX_SLOTS);

    always_comb begin
        rej_early = 1'b1;
        if (r_cap != '0) begin
            case (i_data.command)
                ffsa_pkg::CMD_RESERVE: begin
                    rej_early = (tag_m == '0);
                end
                ffsa_pkg::CMD_RELEASE, ffsa_pkg::CMD_QUERY: begin
                    rej_early = !idx_ok;
                end
                default: begin
                    rej_early = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffsa_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (rej_early) begin
                        n_state = ffsa_pkg::S_OUT;
                    end else if (i_data.command == ffsa_pkg::CMD_RESERVE) begin
                        n_state = ffsa_pkg::S_GROUP;
                    end else begin
                        n_state = ffsa_pkg::S_READ;
                    end
                end
            end
            ffsa_pkg::S_GROUP: begin
                n_state = ffsa_pkg::S_SLOT;
            end
            ffsa_pkg::S_SLOT, ffsa_pkg::S_READ: begin
                n_state = ffsa_pkg::S_OUT;
            end
            ffsa_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = ffsa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffsa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        n_status  = r_status;
        n_value   = r_value;
        n_free    = r_free;
        ram_we    = 1'b0;
        srch_ctrl = '0;
        srch_ctrl.clear_all = cfg_acc;
        srch_ctrl.cap       = cap_sat;
        srch_ctrl.addr      = ffsa_pkg::SLOT_BITS'(r_in.slot_index);
        case (r_state)
            ffsa_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (in_acc && rej_early) begin
                    n_status = ffsa_pkg::ST_REJECT;
                    n_value  = '0;
                end
            end
            ffsa_pkg::S_GROUP: begin
                srch_ctrl.grp_load = 1'b1;
            end
            ffsa_pkg::S_SLOT: begin
                srch_ctrl.addr = srch_stat.slot;
                if (srch_stat.hit) begin
                    ram_we           = 1'b1;
                    srch_ctrl.set_en = 1'b1;
                    n_status         = ffsa_pkg::ST_OK;
                    n_value          = ffsa_pkg::VAL_BITS'(srch_stat.slot);
                    if (r_free != '0) begin
                        n_free = r_free - 1'b1;
                    end
                end else begin
                    n_status = ffsa_pkg::ST_REJECT;
                    n_value  = '0;
                end
            end
            ffsa_pkg::S_READ: begin
                if (r_in.command == ffsa_pkg::CMD_QUERY) begin
                    n_status = ffsa_pkg::ST_OK;
                    n_value  = srch_stat.occ ? ram_rdata : '0;
                end else if (srch_stat.occ) begin
                    srch_ctrl.clr_en = 1'b1;
                    n_status         = ffsa_pkg::ST_OK;
                    n_value          = ram_rdata;
                    if (r_free < r_cap) begin
                        n_free = r_free + 1'b1;
                    end
                end else begin
                    n_status = ffsa_pkg::ST_REJECT;
                    n_value  = '0;
                end
            end
            ffsa_pkg::S_OUT: begin
                o_valid = 1'b1;
            end
            default: begin
                o_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffsa_pkg::S_IDLE;
            r_cap   <= '0;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_cap  <= cap_sat;
                r_free <= cap_sat;
            end else begin
                r_free <= n_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        if (in_acc) begin
            r_in  <= i_data;
            r_tag <= tag_m;
        end
    end

    ffsa_free_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (srch_ctrl),
        .o_stat  (srch_stat)
    );

    ffsa_tag_ram #(
        .DEPTH (ffsa_pkg::MAX_SLOTS),
        .WIDTH (ffsa_pkg::OWN_BITS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (srch_stat.slot),
        .i_wdata (r_tag),
        .i_re    (in_acc),
        .i_raddr (ffsa_pkg::SLOT_BITS'(i_data.slot_index)),
        .o_rdata (ram_rdata)
    );

    assign o_data.status       = r_status;
    assign o_data.result_value = r_value;
    assign o_data.free_slots   = r_free;
    assign o_data.used_slots   = r_cap - r_free;

    a_free_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_cap)
        else $error("free count above capacity");

    a_no_accept_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while a result beat waits");

    a_cfg_sets_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> (r_free == r_cap))
        else $error("capacity write did not reload free count");

    a_hit_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffsa_pkg::S_SLOT && srch_stat.hit) |-> (r_free != '0))
        else $error("free slot found with zero free count");

endmodule

[verif/ffsa_checker.sv]
// ----------------------------------------------------------------------------
// ffsa_checker
// Watches the capacity, command and response channels of the first-fit slot
// allocator, keeps its own owner table and free count, predicts the response
// of every command beat and compares each response beat field by field.
// ----------------------------------------------------------------------------
module ffsa_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [ffsa_pkg::CNT_BITS-1:0] i_cfg_data,
    input  logic                          i_cmd_valid,
    input  logic                          i_cmd_ready,
    input  ffsa_pkg::t_in_beat            i_cmd_beat,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  ffsa_pkg::t_out_beat           i_rsp_beat,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_compared,
    output int                            o_granted,
    output int                            o_rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ffsa_pkg::OWN_BITS-1:0] owners [ffsa_pkg::MAX_SLOTS];
    logic [ffsa_pkg::CNT_BITS-1:0] slots_cap;
    logic [ffsa_pkg::CNT_BITS-1:0] slots_free;
    ffsa_pkg::t_out_beat           rsp_q [$];
    int                            n_err;
    int                            n_cmp;
    int                            n_grant;
    int                            n_rej;

    function automatic void wipe_table();
        int s;
        for (s = 0; s < ffsa_pkg::MAX_SLOTS; s++) begin
            owners[s] = '0;
        end
    endfunction

    function automatic ffsa_pkg::t_out_beat serve_command(input ffsa_pkg::t_in_beat b);
        ffsa_pkg::t_out_beat           r;
        logic [ffsa_pkg::OWN_BITS-1:0] tag;
        logic                          found;
        int                            s;
        r        = '0;
        r.status = ffsa_pkg::ST_REJECT;
        tag      = b.owner_tag & ffsa_pkg::TAG_MASK;
        found    = 1'b0;
        if (slots_cap != 0) begin
            case (b.command)
                ffsa_pkg::CMD_RESERVE: begin
                    if (tag != 0) begin
                        for (s = 0; s < ffsa_pkg::MAX_SLOTS; s++) begin
                            if (!found && s < slots_cap && owners[s] == 0) begin
                                owners[s] = tag;
                                if (slots_free > 0) slots_free = slots_free - 1'b1;
                                r.status       = ffsa_pkg::ST_OK;
                                r.result_value = ffsa_pkg::VAL_BITS'(s);
                                found          = 1'b1;
                            end
                        end
                    end
                end
                ffsa_pkg::CMD_RELEASE: begin
                    if (b.slot_index < slots_cap && owners[b.slot_index] != 0) begin
                        r.status               = ffsa_pkg::ST_OK;
                        r.result_value         = ffsa_pkg::VAL_BITS'(owners[b.slot_index]);
                        owners[b.slot_index]   = '0;
                        if (slots_free < slots_cap) slots_free = slots_free + 1'b1;
                    end
                end
                ffsa_pkg::CMD_QUERY: begin
                    if (b.slot_index < slots_cap) begin
                        r.status       = ffsa_pkg::ST_OK;
                        r.result_value = ffsa_pkg::VAL_BITS'(owners[b.slot_index]);
                    end
                end
                default: begin
                    r.status = ffsa_pkg::ST_REJECT;
                end
            endcase
        end
        r.free_slots = slots_free;
        r.used_slots = (slots_cap >= slots_free) ? slots_cap - slots_free : '0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        ffsa_pkg::t_out_beat want;
        ffsa_pkg::t_out_beat got;
        if (!i_rst_n) begin
            wipe_table();
            slots_cap  = '0;
            slots_free = '0;
            rsp_q.delete();
            n_err   = 0;
            n_cmp   = 0;
            n_grant = 0;
            n_rej   = 0;
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_beat;
                if (rsp_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("[%0t] response beat with none outstanding: st=%0d val=%h free=%0d used=%0d",
                                 $realtime, got.status, got.result_value, got.free_slots,
                                 got.used_slots);
                    end
                end else begin
                    want = rsp_q.pop_front();
                    n_cmp++;
                    if (got.status != want.status || got.result_value != want.result_value ||
                        got.free_slots != want.free_slots || got.used_slots != want.used_slots) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("[%0t] response mismatch #%0d", $realtime, n_cmp);
                            $display("    exp: st=%0d val=%h free=%0d used=%0d", want.status,
                                     want.result_value, want.free_slots, want.used_slots);
                            $display("    act: st=%0d val=%h free=%0d used=%0d", got.status,
                                     got.result_value, got.free_slots, got.used_slots);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                slots_cap  = (i_cfg_data > ffsa_pkg::MAX_SLOTS) ?
                             ffsa_pkg::CNT_BITS'(ffsa_pkg::MAX_SLOTS) : i_cfg_data;
                wipe_table();
                slots_free = slots_cap;
            end
            if (i_cmd_valid && i_cmd_ready) begin
                want = serve_command(i_cmd_beat);
                rsp_q.push_back(want);
                if (want.status == ffsa_pkg::ST_REJECT) n_rej++;
                else if (i_cmd_beat.command == ffsa_pkg::CMD_RESERVE) n_grant++;
            end
        end
        o_pending  <= rsp_q.size();
        o_errors   <= n_err;
        o_compared <= n_cmp;
        o_granted  <= n_grant;
        o_rejected <= n_rej;
    end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the first-fit slot allocator through a directed pass over its corner
// cases and random command streams under several capacities, with random
// gaps and stalls plus one long response hold-off; the checker predicts and
// compares every response and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNDEFINED  = 2'd3;
    localparam int         IDLE_PCT       = 26;
    localparam int         HOLDOFF_CYCLES = 300;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         NUM_PHASES     = 9;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ffsa_pkg::CNT_BITS-1:0] cfg_data  = '0;
    logic                          cmd_valid = 1'b0;
    logic                          cmd_ready;
    ffsa_pkg::t_in_beat            cmd_beat  = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    ffsa_pkg::t_out_beat           rsp_beat;

    int   errors;
    int   pending;
    int   compared;
    int   granted;
    int   rejected;
    int   n_sent       = 0;
    int   n_caps       = 0;
    int   stall_left   = 0;
    int   idle_cycles  = 0;
    logic steady       = 1'b0;
    int   holdoff_reqs = 0;
    int   holdoff_done = 0;

    always #1 clk = ~clk;

    first_fit_slot_allocator_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_valid     (cmd_valid),
        .o_ready     (cmd_ready),
        .i_data      (cmd_beat),
        .o_valid     (rsp_valid),
        .i_ready     (rsp_ready),
        .o_data      (rsp_beat)
    );

    ffsa_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .i_cmd_beat  (cmd_beat),
        .i_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .i_rsp_beat  (rsp_beat),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_compared  (compared),
        .o_granted   (granted),
        .o_rejected  (rejected)
    );

    always @(posedge clk) begin
        if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (holdoff_done != holdoff_reqs) begin
            rsp_ready    <= 1'b0;
            stall_left   <= HOLDOFF_CYCLES;
            holdoff_done <= holdoff_done + 1;
        end else if (steady) begin
            rsp_ready <= 1'b1;
        end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cfg_valid && cfg_ready) || (cmd_valid && cmd_ready) ||
            (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic offer(input logic [1:0] code, input logic [ffsa_pkg::IDX_BITS-1:0] idx,
                         input logic [ffsa_pkg::OWN_BITS-1:0] tag);
        ffsa_pkg::t_in_beat b;
        b.command    = ffsa_pkg::t_cmd'(code);
        b.slot_index = idx;
        b.owner_tag  = tag;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            cmd_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
        cmd_valid <= 1'b1;
        cmd_beat  <= b;
        do @(posedge clk); while (!cmd_ready);
        n_sent++;
    endtask

    task automatic offer_random(input int cap);
        int                            pick;
        logic [1:0]                    code;
        logic [ffsa_pkg::IDX_BITS-1:0] idx;
        logic [ffsa_pkg::OWN_BITS-1:0] tag;
        pick = $urandom_range(0, 99);
        if (pick < 50)      code = ffsa_pkg::CMD_RESERVE;
        else if (pick < 80) code = ffsa_pkg::CMD_RELEASE;
        else if (pick < 95) code = ffsa_pkg::CMD_QUERY;
        else                code = CMD_UNDEFINED;
        if (cap > 0 && $urandom_range(0, 99) < 85) begin
            idx = ffsa_pkg::IDX_BITS'($urandom_range(0, cap - 1));
        end else begin
            idx = ffsa_pkg::IDX_BITS'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < 3) tag = '0;
        else                           tag = ffsa_pkg::OWN_BITS'($urandom_range(1, 65535));
        offer(code, idx, tag);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [ffsa_pkg::CNT_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_caps++;
    endtask

    initial begin
        int phase_caps  [NUM_PHASES];
        int phase_items [NUM_PHASES];
        int eff;
        phase_caps  = '{511, 5, 2, 37, 256, 1, 300, 0, 16};
        phase_items = '{90, 50, 40, 50, 90, 30, 40, 20, 50};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no table after reset
        offer(ffsa_pkg::CMD_RESERVE, 8'd0, 16'h0001);
        offer(ffsa_pkg::CMD_RELEASE, 8'd0, 16'h0000);
        offer(ffsa_pkg::CMD_QUERY, 8'd0, 16'h0000);
        offer(CMD_UNDEFINED, 8'd0, 16'h1234);
        drain();

        write_capacity(9'd1);
        offer(ffsa_pkg::CMD_RESERVE, 8'd0, 16'h0000);
        offer(ffsa_pkg::CMD_RESERVE, 8'd7, 16'hFFFF);
        offer(ffsa_pkg::CMD_RESERVE, 8'd0, 16'h0001);
        offer(ffsa_pkg::CMD_QUERY, 8'd0, 16'h0000);
        offer(ffsa_pkg::CMD_QUERY, 8'd1, 16'h0000);
        offer(ffsa_pkg::CMD_QUERY, 8'd255, 16'h0000);
        offer(ffsa_pkg::CMD_RELEASE, 8'd255, 16'h0000);
        offer(ffsa_pkg::CMD_RELEASE, 8'd0, 16'h0000);
        offer(ffsa_pkg::CMD_RELEASE, 8'd0, 16'h0000);
        offer(ffsa_pkg::CMD_QUERY, 8'd0, 16'h0000);
        offer(ffsa_pkg::CMD_RESERVE, 8'd255, 16'h8000);
        offer(CMD_UNDEFINED, 8'd0, 16'hFFFF);
        drain();

        write_capacity(9'd511);
        offer(ffsa_pkg::CMD_RESERVE, 8'd0, 16'hAAAA);
        offer(ffsa_pkg::CMD_RESERVE, 8'd0, 16'h5555);
        offer(ffsa_pkg::CMD_QUERY, 8'd255, 16'h0000);
        offer(ffsa_pkg::CMD_RELEASE, 8'd255, 16'h0000);
        offer(CMD_UNDEFINED, 8'd255, 16'h0000);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            eff = (phase_caps[p] > ffsa_pkg::MAX_SLOTS) ? ffsa_pkg::MAX_SLOTS : phase_caps[p];
            write_capacity(ffsa_pkg::CNT_BITS'(phase_caps[p]));
            steady <= (p == 4);
            if (p == 3) holdoff_reqs <= holdoff_reqs + 1;
            for (int k = 0; k < phase_items[p]; k++) begin
                offer_random(eff);
            end
            drain();
        end
        steady <= 1'b0;
        repeat (8) @(posedge clk);

        $display("Sent %0d commands over %0d capacity writes; %0d slots granted, %0d rejected.",
                 n_sent, n_caps, granted, rejected);
        $display("Compared %0d responses, including a %0d-cycle response hold-off.",
                 compared, HOLDOFF_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
